// ===== sv/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply package
// Item types, field widths, register indexes and item kinds shared by the
// matrix multiply block and its element stores.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned DIM_W         = 4;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned MAX_DIM_DEF   = 8;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PROD_W        = 2 * DATA_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS     = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row_res;
    logic [IDX_W-1:0]         col_res;
    logic signed [DATA_W-1:0] value_res;
    logic                     last;
  } out_item_t;

endpackage

// ===== sv/mm_store.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply element store
// One-write, one-read element memory with registered read data. A valid bit
// per entry makes an entry that was never written read as zero after reset.
// ----------------------------------------------------------------------------
module mm_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic signed [mm_pkg::DATA_W-1:0]  wdata_i,
  input  logic [AW-1:0]                     raddr_i,
  output logic signed [mm_pkg::DATA_W-1:0]  rdata_o
);
  import mm_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]         valid_q;
  logic signed [DATA_W-1:0] rd_q;
  logic                     rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== sv/matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply
// Signed fixed-point product C = A * B with one shared multiply-accumulate.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): a load item writes one
// element of A or B at (row, col); a write with row or col at or beyond
// MAX_DIM is dropped. A compute item walks C in row-major order and sends
// M*P result items on the output channel, the final one with last set.
// Each element issues its N terms through the single 32x32 multiplier, drains
// the read and multiply stages, then scales and saturates and presents the
// result; an output stall holds it longer. A compute item keeps the input
// stalled until its final result is taken.
// Dimensions come from the a_rows, inner_size and b_cols registers (0 acts as
// 1, above MAX_DIM acts as MAX_DIM); write them only while the block is idle.
// Reset sets all dimensions to 3 and makes both stores read as zero.
// A stalled result holds in the output register and the walk waits on it.
// ----------------------------------------------------------------------------
module matrix_multiply #(
  parameter int unsigned MAX_DIM   = mm_pkg::MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mm_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mm_pkg::in_item_t             in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mm_pkg::out_item_t            out_item_o
);
  import mm_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned ACC_W = PROD_W + $clog2(MAX_DIM) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  function automatic logic [AW-1:0] addr_of(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return AW'(32'(r) * MAX_DIM + 32'(c));
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return d;
    end
  endfunction

  logic [2:0]               state_q, state_d;
  logic [DIM_W-1:0]         a_rows_q, inner_size_q, b_cols_q;
  logic [DIM_W-1:0]         m_dim, n_dim, p_dim;
  logic [IDX_W-1:0]         i_q, i_d, j_q, j_d, k_q, k_d;
  logic                     in_acc, out_acc;
  logic                     wr_ok, a_we, b_we;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] a_rd, b_rd;
  logic                     k_last, i_last, j_last;
  logic                     s1_vld_q, s1_last_q, s2_vld_q, s2_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_shift;
  logic                     acc_clr;
  logic [ACC_W-DATA_W:0]    acc_hi;
  logic signed [DATA_W-1:0] sat_val;
  out_item_t                out_q;

  assign m_dim = eff_dim(a_rows_q);
  assign n_dim = eff_dim(inner_size_q);
  assign p_dim = eff_dim(b_cols_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_item_o  = out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q     <= DIM_RESET;
      inner_size_q <= DIM_RESET;
      b_cols_q     <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_A_ROWS:     a_rows_q     <= cfg_data_i;
        REG_INNER_SIZE: inner_size_q <= cfg_data_i;
        REG_B_COLS:     b_cols_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Element loads
  assign wr_ok = (32'(in_item_i.row) < MAX_DIM) && (32'(in_item_i.col) < MAX_DIM);
  assign waddr = addr_of(in_item_i.row, in_item_i.col);
  assign a_we  = in_acc && wr_ok && (in_item_i.kind == KIND_LOAD_A);
  assign b_we  = in_acc && wr_ok && (in_item_i.kind == KIND_LOAD_B);

  mm_store #(.DEPTH(DEPTH), .AW(AW)) u_a_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.value),
    .raddr_i (addr_of(i_q, k_q)),
    .rdata_o (a_rd)
  );

  mm_store #(.DEPTH(DEPTH), .AW(AW)) u_b_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.value),
    .raddr_i (addr_of(k_q, j_q)),
    .rdata_o (b_rd)
  );

  assign k_last = ({1'b0, k_q} == n_dim - DIM_W'(1));
  assign i_last = ({1'b0, i_q} == m_dim - DIM_W'(1));
  assign j_last = ({1'b0, j_q} == p_dim - DIM_W'(1));

  // Sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    acc_clr = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_item_i.kind == KIND_COMPUTE) begin
          state_d = S_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          acc_clr = 1'b1;
        end
      end
      S_RUN: begin
        if (k_last) begin
          state_d = S_WAIT;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (s2_vld_q && s2_last_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          k_d     = '0;
          acc_clr = 1'b1;
          state_d = S_RUN;
          if (j_last) begin
            j_d = '0;
            if (i_last) begin
              state_d = S_IDLE;
            end else begin
              i_d = i_q + IDX_W'(1);
            end
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      s1_vld_q  <= (state_q == S_RUN);
      s1_last_q <= k_last;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Multiply, then accumulate the exact sum
  always_ff @(posedge clk_i) begin
    prod_q <= a_rd * b_rd;
    if (acc_clr) begin
      acc_q <= '0;
    end else if (s2_vld_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Floor scaling and saturation
  assign acc_shift = acc_q >>> FRAC_BITS;
  assign acc_hi    = acc_shift[ACC_W-1:DATA_W-1];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_val = acc_shift[DATA_W-1:0];
    end else if (acc_hi[ACC_W-DATA_W]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN) begin
      out_q.row_res   <= i_q;
      out_q.col_res   <= j_q;
      out_q.value_res <= sat_val;
      out_q.last      <= i_last && j_last;
    end
  end

  // Checks
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result offered while input side is open");

  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (state_q == S_RUN || state_q == S_WAIT))
    else $error("multiply pipeline active outside a term walk");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_item_o.last) |=> (state_q == S_IDLE))
    else $error("walk continued after final result");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.kind == KIND_COMPUTE) |=> (state_q == S_RUN && k_q == '0))
    else $error("compute item did not start a walk");

endmodule
